### rtl/cdq_pkg.sv
// Package for the circular deque: operation and status codes, stream field
// layout, default sizes and the command/status structs between control and
// datapath. No dependencies.
package cdq_pkg;

   // Default sizes, handed to the top-level parameters.
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // Fixed field widths of the stream payloads.
   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 4;
   localparam int DATA_IN_W   = 32;
   localparam int DATA_OUT_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Request payload layout, lowest bit first.
   localparam int OPC_LSB     = 0;
   localparam int POS_LSB     = OPC_LSB + OPCODE_W;
   localparam int DIN_LSB     = POS_LSB + POS_W;
   localparam int REQ_USED_W  = DIN_LSB + DATA_IN_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response payload layout, lowest bit first.
   localparam int RSP_USED_W  = DATA_OUT_W + STATUS_W + COUNT_OUT_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ_AT    = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_WRITE_AT   = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic execute;    // update pointers and access the store
      logic load_read;  // take the registered store read into the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_read; // the executing operation returns a stored value
   } sts_type;

endpackage

### rtl/cdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cdq_ctrl.sv
// Controller of the circular deque: sequences capture, execute, store read
// and response hand-off for one transaction at a time.
// Depends on cdq_pkg.
module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  cdq_pkg::sts_type sts,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      cmd.load_read = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = sts.needs_read ? S_READ : S_RESP;
         end
         S_READ: begin
            cmd.load_read = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

endmodule

### rtl/cdq_datapath.sv
// Datapath of the circular deque: request and response registers, ring
// pointers, item count and the ring store.
// Depends on cdq_pkg and cdq_ram.
module cdq_datapath #(
   parameter int DEPTH      = cdq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cdq_pkg::cmd_type                 cmd,
   output cdq_pkg::sts_type                 sts,
   input  logic [cdq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic [cdq_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import cdq_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SW   = ((AW > POS_W) ? AW : POS_W) + 1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

   // Captured request.
   logic [OPCODE_W-1:0]   op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] din_ff;
   logic [63:0]           din_wide;

   // Ring state.
   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;

   // Response registers.
   logic [DATA_OUT_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   status_in;

   // Store access.
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [63:0]           rd_wide;

   // Address arithmetic.
   logic [AW-1:0] front_dec, front_inc, back_dec, back_inc;
   logic [SW-1:0] slot_sum, slot_wrap;
   logic [AW-1:0] slot;
   logic          is_full, is_empty, pos_ok, needs_read;
   logic [31:0]   count_wide;

   // Request capture; only the low DATA_WIDTH bits of the value are kept.
   assign din_wide = 64'(req_tdata[DIN_LSB +: DATA_IN_W]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tdata[OPC_LSB +: OPCODE_W];
         pos_ff <= req_tdata[POS_LSB +: POS_W];
         din_ff <= din_wide[DATA_WIDTH-1:0];
      end
   end

   // Wrapping pointer steps and the logical-to-physical slot.
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;
   assign back_inc  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;
   assign slot_sum  = SW'(front_ff) + SW'(pos_ff);
   assign slot_wrap = (slot_sum >= DEPTH_SUM) ? slot_sum - DEPTH_SUM : slot_sum;
   assign slot      = slot_wrap[AW-1:0];
   assign is_full   = (count_ff == FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign pos_ok    = (CMPW'(pos_ff) < CMPW'(count_ff));

   // A pop on a non-empty deque or an in-range read returns a stored value.
   assign needs_read = (((op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK)) && !is_empty) ||
                       ((op_ff == OP_READ_AT) && pos_ok);

   // Operation decode.
   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_waddr  = '0;
      ram_raddr  = '0;
      if (cmd.execute) begin
         unique case (op_ff)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  front_in  = front_dec;
                  ram_we    = 1'b1;
                  ram_waddr = front_dec;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  back_in   = back_inc;
                  ram_we    = 1'b1;
                  ram_waddr = back_inc;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = front_ff;
                  front_in   = front_inc;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = back_ff;
                  back_in    = back_dec;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_READ_AT: begin
               if (!pos_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = slot;
               end
            end
            OP_WRITE_AT: begin
               if (!pos_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = slot;
               end
            end
            default: begin
               // Unused codes do nothing and report success.
               status_in = ST_OK;
            end
         endcase
      end
   end

   assign sts.needs_read = needs_read;

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= LAST_IDX;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Ring store.
   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (din_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Response registers; the value is zero unless a store read follows.
   assign rd_wide = 64'(ram_rdata);

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= status_in;
         rsp_data_ff   <= '0;
      end else if (cmd.load_read) begin
         rsp_data_ff <= rd_wide[DATA_OUT_W-1:0];
      end
   end

   // Response packing.
   assign count_wide = 32'(count_ff);
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, count_wide[COUNT_OUT_W-1:0],
                        rsp_status_ff, rsp_data_ff};

endmodule

### rtl/circular_deque.sv
// Circular deque top level: one transaction at a time, a new request only
// after the last result is taken, set by the controller sequence idle,
// execute, store read, respond; the store-read state serves only pops and
// reads that return a value, for the registered store read. Synchronous
// active-high reset empties the deque at once; store contents are left as
// they are.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
module circular_deque #(
   parameter int DEPTH      = cdq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = cdq_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode[2:0], position[6:3], data_in[38:7], zero[39]
   input  logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // data_out[31:0], status[33:32], item_count[38:34], zero[39]
   output logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cdq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Transaction sequencer.
   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Pointers, count and ring store.
   cdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### rtl/cdq_checker.sv
// Port-level checker for the circular deque, bound to the top level.
// Depends on cdq_pkg and circular_deque.
module cdq_checker #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cdq_pkg::*;

   logic [DATA_OUT_W-1:0]  rsp_data;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic                   req_fire;

   assign rsp_data   = rsp_tdata[DATA_OUT_W-1:0];
   assign rsp_status = rsp_tdata[DATA_OUT_W +: STATUS_W];
   assign rsp_count  = rsp_tdata[DATA_OUT_W + STATUS_W +: COUNT_OUT_W];
   assign req_fire   = req_tvalid && req_tready;

   // The block never takes a request while a result is on offer.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   // No result can appear in the cycle after a request is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp_tvalid)
      else $error("result shown too early after a request");

   // Failed operations return no data.
   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != ST_OK) |-> (rsp_data == '0))
      else $error("error result carries data");

   // A full report means the deque holds its capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_FULL) |-> (rsp_count == COUNT_OUT_W'(DEPTH)))
      else $error("full reported with a count below capacity");

   // An empty report means the deque holds nothing.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_EMPTY) |-> (rsp_count == '0))
      else $error("empty reported with items stored");

endmodule

bind circular_deque cdq_checker #(
   .DEPTH (DEPTH)
) u_cdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
